// ===== rtl/core/rge_pkg.sv =====
// Package for the random graph edge generator.
// Holds sizes, generator constants, register codes, FSM and multiplier types.
// No dependencies.
`timescale 1ns / 1ps

package rge_pkg;

  // Graph size limits
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned IDX_W     = 10;         // node index width
  localparam int unsigned N_W       = IDX_W + 1;  // holds MAX_NODES itself
  localparam int unsigned PCT_W     = 7;

  // Generator x = x * LCG_MUL + LCG_ADD (mod 2^32)
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  // floor(v / 100) = (v * RECIP_100) >> RECIP_SHIFT, exact for v < 2^31
  localparam logic [31:0] RECIP_100   = 32'd2748779070;
  localparam int unsigned RECIP_SHIFT = 38;
  // two's complement of 100, so v + q * NEG_100 = v - 100 q
  localparam logic [31:0] NEG_100     = 32'hFFFF_FF9C;

  // Configuration register indexes
  localparam logic [1:0] REG_NODE_COUNT   = 2'd0;
  localparam logic [1:0] REG_EDGE_PERCENT = 2'd1;
  localparam logic [1:0] REG_SEED_VALUE   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG2,
    ST_LCG3,
    ST_RECIP,
    ST_REM,
    ST_OUT
  } state_e;

  // Request to the shared multiply-add unit
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } mul_req_t;

endpackage

// ===== rtl/core/rge_mul_unit.sv =====
// Shared multiply-add unit: registered 64-bit result of a * b + c.
// Depends on rge_pkg for the request type.
`timescale 1ns / 1ps

module rge_mul_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rge_pkg::mul_req_t req_i,
  output logic [63:0]       prod_o
);
  import rge_pkg::*;

  logic [63:0] prod_d, prod_q;

  // one 32x32 multiply plus addend per cycle
  assign prod_d = ({32'd0, req_i.a} * {32'd0, req_i.b}) + {32'd0, req_i.c};

  // payload only, reset kept for a clean start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/random_graph_edge_generator.sv =====
// Top level of the random graph edge generator.
// Depends on rge_pkg and rge_mul_unit.
`timescale 1ns / 1ps

// Walks the upper triangle of an n-node adjacency matrix, one pair (i, j), i < j, per
// input transfer, and returns row, column, an edge bit and a last-pair mark (tlast).
// Each pair steps from its accept in ST_IDLE through ST_LCG2, ST_LCG3, ST_RECIP and ST_REM to ST_OUT,
// since one 32x32 multiply-add unit is used five times per pair (three generator steps, a
// reciprocal multiply and a remainder step for the modulo by 100). A finished result sits
// in an output register, so the next pair is accepted while it waits. tdata bit 0 set
// reloads the generator from seed_value and restarts the walk at (0,1). Configuration
// writes are always accepted and must be made while the block is idle.

module random_graph_edge_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] row, [19:10] col, [20] edge_res, [23:21] zero
  output logic        m_axis_tlast
);
  import rge_pkg::*;

  // configuration registers
  logic [N_W-1:0]   node_count_q;
  logic [PCT_W-1:0] edge_percent_q;
  logic [31:0]      seed_value_q;

  // walk and generator state
  logic [31:0]      gen_q, gen_d;
  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;

  // per-pair working registers
  state_e           state_q, state_d;
  logic [IDX_W-1:0] pi_q, pi_d, pj_q, pj_d;
  logic             plast_q, plast_d;
  logic [30:0]      v_q, v_d;

  // output register
  logic             ovalid_q, ovalid_d;
  logic [IDX_W-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic             oedge_q, oedge_d, olast_q, olast_d;

  mul_req_t         mreq;
  logic [63:0]      prod;

  logic             s_fire, m_fire, cfg_fire;
  logic [N_W-1:0]   eff_n;
  logic [IDX_W-1:0] r0, c0, ri, cj;
  logic [N_W-1:0]   ri_w, cj_w;
  logic [7:0]       rem_p1;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = m_axis_tvalid && m_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  assign cfg_ready_o = 1'b1;

  // input taken only between pairs
  assign s_axis_tready = (state_q == ST_IDLE);

  // configuration writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= N_W'(MAX_NODES);
      edge_percent_q <= PCT_W'(50);
      seed_value_q   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_addr_i)
        REG_NODE_COUNT:   node_count_q   <= cfg_data_i[N_W-1:0];
        REG_EDGE_PERCENT: edge_percent_q <= cfg_data_i[PCT_W-1:0];
        REG_SEED_VALUE:   seed_value_q   <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // node count saturated into 2..MAX_NODES
  always_comb begin
    if (node_count_q < N_W'(2)) begin
      eff_n = N_W'(2);
    end else if (node_count_q > N_W'(MAX_NODES)) begin
      eff_n = N_W'(MAX_NODES);
    end else begin
      eff_n = node_count_q;
    end
  end

  // pair for this transfer: restart, then fall back to (0,1) if off the triangle
  always_comb begin
    if (s_axis_tdata[0]) begin
      r0 = '0;
      c0 = IDX_W'(1);
    end else begin
      r0 = row_q;
      c0 = col_q;
    end
    if ((r0 < c0) && ({1'b0, c0} < eff_n)) begin
      ri = r0;
      cj = c0;
    end else begin
      ri = '0;
      cj = IDX_W'(1);
    end
    ri_w = {1'b0, ri};
    cj_w = {1'b0, cj};
  end

  rge_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .prod_o (prod)
  );

  assign rem_p1 = {1'b0, prod[6:0]} + 8'd1;

  // sequencer: issues to the shared unit and collects its results
  always_comb begin
    state_d  = state_q;
    gen_d    = gen_q;
    row_d    = row_q;
    col_d    = col_q;
    pi_d     = pi_q;
    pj_d     = pj_q;
    plast_d  = plast_q;
    v_d      = v_q;
    ovalid_d = ovalid_q && !m_fire;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    oedge_d  = oedge_q;
    olast_d  = olast_q;
    mreq     = '{en: 1'b0, a: gen_q, b: LCG_MUL, c: LCG_ADD};

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          // first generator step
          mreq.en = 1'b1;
          mreq.a  = s_axis_tdata[0] ? seed_value_q : gen_q;
          pi_d    = ri;
          pj_d    = cj;
          plast_d = (ri_w == eff_n - N_W'(2)) && (cj_w == eff_n - N_W'(1));
          // advance the walk
          if (cj_w + N_W'(1) < eff_n) begin
            row_d = ri;
            col_d = cj + IDX_W'(1);
          end else if (ri_w + N_W'(2) < eff_n) begin
            row_d = ri + IDX_W'(1);
            col_d = ri + IDX_W'(2);
          end else begin
            row_d = '0;
            col_d = IDX_W'(1);
          end
          state_d = ST_LCG2;
        end
      end
      ST_LCG2: begin
        v_d[30:20] = prod[26:16];
        mreq.en    = 1'b1;
        mreq.a     = prod[31:0];
        state_d    = ST_LCG3;
      end
      ST_LCG3: begin
        v_d[19:10] = prod[25:16];
        mreq.en    = 1'b1;
        mreq.a     = prod[31:0];
        state_d    = ST_RECIP;
      end
      ST_RECIP: begin
        // third step done: keep state, start quotient
        gen_d     = prod[31:0];
        v_d[9:0]  = prod[25:16];
        mreq.en   = 1'b1;
        mreq.a    = {1'b0, v_q[30:10], prod[25:16]};
        mreq.b    = RECIP_100;
        mreq.c    = '0;
        state_d   = ST_REM;
      end
      ST_REM: begin
        // v - 100 * floor(v / 100)
        mreq.en = 1'b1;
        mreq.a  = {{(64 - RECIP_SHIFT - 26 + 6){1'b0}}, prod[63:RECIP_SHIFT]};
        mreq.b  = NEG_100;
        mreq.c  = {1'b0, v_q};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_fire) begin
          ovalid_d = 1'b1;
          orow_d   = pi_q;
          ocol_d   = pj_q;
          oedge_d  = rem_p1 <= {1'b0, edge_percent_q};
          olast_d  = plast_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      gen_q    <= '0;
      row_q    <= '0;
      col_q    <= IDX_W'(1);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      gen_q    <= gen_d;
      row_q    <= row_d;
      col_q    <= col_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pi_q    <= pi_d;
    pj_q    <= pj_d;
    plast_q <= plast_d;
    v_q     <= v_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    oedge_q <= oedge_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, oedge_q, ocol_q, orow_q};
  assign m_axis_tlast  = olast_q;

  // a pair never issues back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input accepted while a pair is in progress");

  // results always lie in the upper triangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ocol_q > orow_q))
    else $error("result pair not in upper triangle");

  // last mark only on the final column of the effective size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> ({1'b0, ocol_q} == eff_n - N_W'(1)))
    else $error("last mark on a pair that is not final");

endmodule

// ===== dv/rge_pair_checker.sv =====
// Scoreboard for the random graph edge generator: predicts the pair result of
// every input transfer and compares it with the output stream.
// Depends on rge_pkg.
`timescale 1ns / 1ps

module rge_pair_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel, observed
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  // input stream, observed
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,    // [0] restart, [7:1] zero
  // output stream, observed
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,   // [9:0] row, [19:10] col, [20] edge_res, [23:21] zero
  input  logic        out_last_i,
  // status to the testbench top
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned edges_o
);
  import rge_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             edge_res;
    logic             last;
  } pair_result_t;

  // Shadow copy of the configuration registers
  logic [N_W-1:0]   nodes_reg;
  logic [PCT_W-1:0] percent_reg;
  logic [31:0]      seed_reg;

  // Predicted generator and walk position
  logic [31:0]      lcg_state;
  int unsigned      walk_row;
  int unsigned      walk_col;

  pair_result_t     pair_results_q[$];

  function automatic logic [31:0] lcg_step(input logic [31:0] x);
    return x * LCG_MUL + LCG_ADD;
  endfunction

  // Draws one pair and advances the walk
  function automatic pair_result_t predict_pair(input logic restart);
    int unsigned  n;
    int unsigned  rem;
    logic [31:0]  x;
    logic [30:0]  draw;
    pair_result_t r;
    n = nodes_reg;
    if (n < 2) n = 2;
    if (n > MAX_NODES) n = MAX_NODES;
    if (restart) begin
      lcg_state = seed_reg;
      walk_row  = 0;
      walk_col  = 1;
    end
    // pair left outside the triangle after a node count change
    if (!(walk_row < walk_col && walk_col < n)) begin
      walk_row = 0;
      walk_col = 1;
    end
    x             = lcg_step(lcg_state);
    draw[30:20]   = x[26:16];
    x             = lcg_step(x);
    draw[19:10]   = x[25:16];
    x             = lcg_step(x);
    draw[9:0]     = x[25:16];
    lcg_state     = x;
    rem           = 32'(draw) % 100;
    r.row         = IDX_W'(walk_row);
    r.col         = IDX_W'(walk_col);
    r.edge_res    = (rem + 1 <= percent_reg);
    r.last        = (walk_row == n - 2) && (walk_col == n - 1);
    // row-major step through the upper triangle, wrapping after the last pair
    if (walk_col + 1 < n) begin
      walk_col = walk_col + 1;
    end else if (walk_row + 2 < n) begin
      walk_col = walk_row + 2;
      walk_row = walk_row + 1;
    end else begin
      walk_row = 0;
      walk_col = 1;
    end
    return r;
  endfunction

  // Track config, predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    pair_result_t want;
    pair_result_t got;
    if (!rst_ni) begin
      nodes_reg    = N_W'(MAX_NODES);
      percent_reg  = PCT_W'(50);
      seed_reg     = '0;
      lcg_state    = '0;
      walk_row     = 0;
      walk_col     = 1;
      pair_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      edges_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_NODE_COUNT:   nodes_reg   = cfg_data_i[N_W-1:0];
          REG_EDGE_PERCENT: percent_reg = cfg_data_i[PCT_W-1:0];
          REG_SEED_VALUE:   seed_reg    = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.row      = out_data_i[9:0];
        got.col      = out_data_i[19:10];
        got.edge_res = out_data_i[20];
        got.last     = out_last_i;
        if (pair_results_q.size() == 0) begin
          $error("unexpected result transfer: row %0d, col %0d", got.row, got.col);
          fail_count_o++;
        end else begin
          want = pair_results_q.pop_front();
          if (got.row != want.row) begin
            $error("row mismatch: expected %0d, got %0d", want.row, got.row);
            fail_count_o++;
          end
          if (got.col != want.col) begin
            $error("col mismatch: expected %0d, got %0d", want.col, got.col);
            fail_count_o++;
          end
          if (got.edge_res != want.edge_res) begin
            $error("edge_res mismatch at (%0d,%0d): expected %0b, got %0b",
                   want.row, want.col, want.edge_res, got.edge_res);
            fail_count_o++;
          end
          if (got.last != want.last) begin
            $error("last mismatch at (%0d,%0d): expected %0b, got %0b",
                   want.row, want.col, want.last, got.last);
            fail_count_o++;
          end
          checked_o++;
          if (got.edge_res) edges_o++;
        end
      end
      if (in_valid_i && in_ready_i) pair_results_q.push_back(predict_pair(in_data_i[0]));
      pending_o = pair_results_q.size();
    end
  end

endmodule

// ===== dv/tb_random_graph_edge_generator.sv =====
// Testbench top for the random graph edge generator: clock, reset, config
// writes, pair requests with random gaps, output back-pressure and the verdict.
// Depends on rge_pkg, random_graph_edge_generator and rge_pair_checker.
`timescale 1ns / 1ps

module tb_random_graph_edge_generator;
  import rge_pkg::*;

  localparam logic [1:0]  REG_UNUSED   = 2'd3;   // index with no register behind it
  localparam int unsigned ITEM_TARGET  = 1150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // [9:0] row, [19:10] col, [20] edge_res, [23:21] zero
  logic        out_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned edges_seen;
  int unsigned items_sent = 0;
  int unsigned phases     = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b1;  // no gaps on either side while set

  random_graph_edge_generator u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_tvalid),
    .s_axis_tready (in_tready),
    .s_axis_tdata  (in_tdata),
    .m_axis_tvalid (out_tvalid),
    .m_axis_tready (out_tready),
    .m_axis_tdata  (out_tdata),
    .m_axis_tlast  (out_tlast)
  );

  rge_pair_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_tvalid),
    .in_ready_i   (in_tready),
    .in_data_i    (in_tdata),
    .out_valid_i  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_data_i   (out_tdata),
    .out_last_i   (out_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .edges_o      (edges_seen)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register write; starts and ends on a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_addr  = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One pair request; tvalid stays high so back-to-back requests need no re-raise
  task automatic send_pair(input logic restart);
    int unsigned gap;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Block is idle once every pair has come back
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_directed();
    // straight out of reset: generator zero, walk at (0,1)
    send_pair(1'b0);
    send_pair(1'b0);
    wait_idle();
    // smallest useful graph walked past its wrap, all edges, all-ones seed
    write_reg(REG_NODE_COUNT, 32'd4);
    write_reg(REG_EDGE_PERCENT, 32'd100);
    write_reg(REG_SEED_VALUE, 32'hFFFF_FFFF);
    send_pair(1'b1);
    repeat (6) send_pair(1'b0);
    wait_idle();
    // node count below two clamps; zero percent gives no edges
    write_reg(REG_NODE_COUNT, 32'd0);
    write_reg(REG_EDGE_PERCENT, 32'd0);
    send_pair(1'b1);
    send_pair(1'b0);
    wait_idle();
    // count above the maximum clamps, percent above one hundred, write to unused index
    write_reg(REG_NODE_COUNT, 32'd2047);
    write_reg(REG_EDGE_PERCENT, 32'd127);
    write_reg(REG_SEED_VALUE, 32'h1234_5678);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pair(1'b1);
    send_pair(1'b0);
    wait_idle();
    // shrink the graph mid-walk so the stored pair falls outside the triangle
    write_reg(REG_NODE_COUNT, 32'd5);
    write_reg(REG_EDGE_PERCENT, 32'd37);
    send_pair(1'b1);
    repeat (5) send_pair(1'b0);
    wait_idle();
    write_reg(REG_NODE_COUNT, 32'd3);
    send_pair(1'b0);
    send_pair(1'b0);
    wait_idle();
  endtask

  // Random settings, then a stretch of pairs mostly walking without restart
  task automatic run_random_phase();
    int unsigned sel;
    int unsigned n;
    int unsigned pct;
    int unsigned len;
    logic [31:0] seed;
    logic        first_restart;
    sel = $urandom_range(0, 99);
    if (sel < 55)      n = $urandom_range(2, 12);
    else if (sel < 80) n = $urandom_range(13, 64);
    else if (sel < 90) n = $urandom_range(65, 1024);
    else if (sel < 95) n = $urandom_range(0, 1);
    else               n = $urandom_range(1025, 2047);
    sel = $urandom_range(0, 99);
    if (sel < 8)       pct = 0;
    else if (sel < 16) pct = 100;
    else if (sel < 22) pct = $urandom_range(101, 127);
    else               pct = $urandom_range(1, 99);
    sel = $urandom_range(0, 99);
    if (sel < 5)       seed = '0;
    else if (sel < 10) seed = '1;
    else               seed = $urandom;
    calm = ($urandom_range(0, 3) == 0);
    // upper data bits land outside the narrow registers and must not matter
    if ($urandom_range(0, 3) != 0) write_reg(REG_NODE_COUNT, ($urandom & ~32'h7FF) | n);
    if ($urandom_range(0, 3) != 0) write_reg(REG_EDGE_PERCENT, ($urandom & ~32'h7F) | pct);
    if ($urandom_range(0, 3) != 0) write_reg(REG_SEED_VALUE, seed);
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);
    first_restart = $urandom_range(0, 1);
    len = $urandom_range(8, 80);
    for (int k = 0; k < len; k++) begin
      send_pair(k == 0 ? first_restart : ($urandom_range(0, 99) < 3));
    end
    wait_idle();
    phases++;
  endtask

  // Output back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if (!calm) hold = gap_len();
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
        (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d pairs outstanding",
               quiet_cycles, pending);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_NODE_COUNT;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    run_directed();
    while (items_sent < ITEM_TARGET) run_random_phase();
    calm = 1'b1;
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d pair requests in %0d random phases, %0d results checked, %0d edges",
             items_sent, phases, checked, edges_seen);
    $display("summary: restarts, clamped node counts, 0/100/above-100 percent, unused index,"
             , " walk wrap and mid-walk shrink exercised");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== random_graph_edge_generator.f =====
rtl/core/rge_pkg.sv
rtl/core/rge_mul_unit.sv
rtl/core/random_graph_edge_generator.sv
dv/rge_pair_checker.sv
dv/tb_random_graph_edge_generator.sv
